@@ src/latency_window_average_peak_assert.svh @@
// assertion macros for the latency window average block
// each check is sampled on i_clk and held off while i_rst_n is low
`ifndef LATENCY_WINDOW_AVERAGE_PEAK_ASSERT_SVH
`define LATENCY_WINDOW_AVERAGE_PEAK_ASSERT_SVH

// same-cycle implication
`define LWAP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lwap check failed");

// next-cycle implication
`define LWAP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lwap check failed");

`endif

@@ src/lwap_pkg.sv @@
package lwap_pkg;

    localparam int WINDOW      = 50;
    localparam int SAMPLE_BITS = 32;

    localparam int SAMPLE_W = 32;
    localparam int MEAN_W   = 40;
    localparam int PEAK_W   = 32;
    localparam int FRAC_W   = 8;

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_BITS + FILL_W;
    localparam int DIV_W  = SUM_W + FRAC_W;
    localparam int STEP_W = $clog2(DIV_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_ADD,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

@@ src/lwap_if.sv @@
interface lwap_in_if import lwap_pkg::*;;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lwap_out_if import lwap_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MEAN_W-1:0] mean_value;
    logic [PEAK_W-1:0] peak_value;

    modport source (output valid, output mean_value, output peak_value, input ready);
    modport sink   (input valid, input mean_value, input peak_value, output ready);
endinterface

@@ src/latency_window_average_peak.sv @@
// latency window average with peak hold
// input channel i_in carries one latency sample per transaction; output channel
// o_out carries one transaction per sample: the mean of the last WINDOW samples
// (fewer until the window has filled), unsigned with 8 fractional bits and
// floored, and the largest sample seen since reset
// from acceptance to the result register one sample goes through these steps:
// drop the oldest ring entry once the window is full, add the new sample, then
// a restoring divider that makes one quotient bit a cycle over the 46-bit
// scaled sum, then load the result
// i_in.ready is high only while the sequencer is idle, so a new sample is
// not taken until the last one has reached the result register; the ring is a
// 50-entry memory with one write and one registered read port
// the result sits in an output register; while the receiver stalls the block
// still accepts and works on the next sample, and it waits in its last step
// until the held result has been taken
// synchronous reset (i_rst_n low) clears the sum, fill count, ring pointer,
// peak and the output valid; the ring itself is not cleared, since an entry is
// only read after it has been written
module latency_window_average_peak import lwap_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lwap_in_if.sink    i_in,
    lwap_out_if.source o_out
);

    // sequencer and datapath registers
    t_state              r_state,     n_state;
    logic [FILL_W-1:0]   r_fill,      n_fill;
    logic [SLOT_W-1:0]   r_slot,      n_slot;
    logic [SUM_W-1:0]    r_sum,       n_sum;
    logic [SAMPLE_BITS-1:0] r_peak,   n_peak;
    logic [STEP_W-1:0]   r_step,      n_step;
    logic                r_out_valid, n_out_valid;

    // payload registers, no reset needed
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [DIV_W-1:0]    r_div,       n_div;
    logic [FILL_W-1:0]   r_rem,       n_rem;
    logic [MEAN_W-1:0]   r_mean,      n_mean;
    logic [PEAK_W-1:0]   r_peak_out,  n_peak_out;

    // sample ring
    logic [SAMPLE_BITS-1:0] r_ring [WINDOW];
    logic [SAMPLE_BITS-1:0] r_ring_q;
    logic                   n_wr_en;

    // restoring divider step
    logic [FILL_W:0]     rem_sh;
    logic                rem_ge;
    logic [FILL_W:0]     rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_div[DIV_W-1]};
        rem_ge  = (rem_sh >= {1'b0, r_fill});
        rem_sub = rem_sh - {1'b0, r_fill};
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_slot      = r_slot;
        n_sum       = r_sum;
        n_peak      = r_peak;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_sample    = r_sample;
        n_div       = r_div;
        n_rem       = r_rem;
        n_mean      = r_mean;
        n_peak_out  = r_peak_out;
        n_wr_en     = 1'b0;

        // result taken by the receiver
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_sample = SAMPLE_BITS'(i_in.sample);
                    n_state  = ST_SUB;
                end
            end
            ST_SUB: begin
                // ring read data for r_slot is ready here
                if (r_fill == FILL_W'(WINDOW)) begin
                    n_sum = r_sum - SUM_W'(r_ring_q);
                end else begin
                    n_fill = r_fill + 1'b1;
                end
                n_wr_en = 1'b1;
                n_slot  = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                if (r_sample > r_peak) begin
                    n_peak = r_sample;
                end
                n_state = ST_ADD;
            end
            ST_ADD: begin
                n_sum   = r_sum + SUM_W'(r_sample);
                n_div   = {n_sum, {FRAC_W{1'b0}}};
                n_rem   = '0;
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                // one restoring step per cycle, quotient shifts into r_div
                n_div  = {r_div[DIV_W-2:0], rem_ge};
                n_rem  = rem_ge ? rem_sub[FILL_W-1:0] : rem_sh[FILL_W-1:0];
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_W - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_mean      = r_div[MEAN_W-1:0];
                    n_peak_out  = PEAK_W'(r_peak);
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_peak      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_slot      <= n_slot;
            r_sum       <= n_sum;
            r_peak      <= n_peak;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_mean     <= n_mean;
        r_peak_out <= n_peak_out;
    end

    // ring memory: one write port, one registered read port at the write pointer
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_ring[r_slot] <= r_sample;
        end
        r_ring_q <= r_ring[r_slot];
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.mean_value = r_mean;
    assign o_out.peak_value = r_peak_out;

endmodule

@@ src/lwap_checker.sv @@
`include "latency_window_average_peak_assert.svh"

module lwap_checker import lwap_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [MEAN_W-1:0] i_mean_value,
    input logic [PEAK_W-1:0] i_peak_value
);

    // the sequencer keeps the block busy after a transaction
    `LWAP_ASSERT_NXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready ##1 !i_in_ready)

    // a stalled result holds
    `LWAP_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
                     i_out_valid && $stable(i_mean_value) && $stable(i_peak_value))

    // a window mean never exceeds the peak held since reset
    `LWAP_ASSERT_IMP(a_mean_le_peak, i_out_valid,
                     i_mean_value <= {i_peak_value, {FRAC_W{1'b0}}})

    // a new result never appears right after an input transaction
    `LWAP_ASSERT_IMP(a_no_instant_result, $rose(i_out_valid), !$past(i_in_valid && i_in_ready))

endmodule

bind latency_window_average_peak lwap_checker u_lwap_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_mean_value (o_out.mean_value),
    .i_peak_value (o_out.peak_value)
);
